// ----- design/ailp_pkg.sv -----
package ailp_pkg;

    // Parse phase of the character scanner
    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_DEC    = 3'd1,
        PH_BFIRST = 3'd2,
        PH_BASED  = 3'd3,
        PH_AFTERB = 3'd4,
        PH_ESTART = 3'd5,
        PH_EFIRST = 3'd6,
        PH_EXP    = 3'd7
    } phase_t;

    // Controller states
    typedef enum logic [1:0] {
        CS_ACCEPT = 2'd0,
        CS_SCALE  = 2'd1,
        CS_OUT    = 2'd2
    } ctrl_state_t;

    typedef logic [2:0] status_t;

    localparam status_t STAT_OK        = 3'd0;
    localparam status_t STAT_BAD_FIRST = 3'd1;
    localparam status_t STAT_DEC_POINT = 3'd2;
    localparam status_t STAT_BAD_BASE  = 3'd3;
    localparam status_t STAT_NEG_EXP   = 3'd4;
    localparam status_t STAT_OVERFLOW  = 3'd5;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UPE   = 8'h45;
    localparam logic [7:0] CH_LOWE  = 8'h65;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPF   = 8'h46;
    localparam logic [7:0] CH_LOWA  = 8'h61;
    localparam logic [7:0] CH_LOWF  = 8'h66;

    localparam logic [4:0] NO_DIGIT  = 5'd16;
    localparam logic [4:0] BASE_TEN  = 5'd10;

    // Controller to datapath
    typedef struct packed {
        logic take;   // character transfer this cycle
        logic scale;  // one exponent scaling step
        logic load;   // load result register, restart parse
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scale_done;
    } dp_stat_t;

endpackage

// ----- design/ailp_ctrl.sv -----
module ailp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_is_last,
    output logic              s_ready,
    input  logic              m_ready,
    output logic              m_valid,
    output ailp_pkg::dp_cmd_t cmd,
    input  ailp_pkg::dp_stat_t stat
);
    import ailp_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_ACCEPT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            CS_ACCEPT: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid && s_is_last) begin
                    state_next = CS_SCALE;
                end
            end
            CS_SCALE: begin
                cmd.scale = 1'b1;
                if (stat.scale_done) begin
                    state_next = CS_OUT;
                end
            end
            CS_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load   = 1'b1;
                    state_next = CS_ACCEPT;
                end
            end
            default: begin
                state_next = CS_ACCEPT;
            end
        endcase

        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- design/ailp_dp.sv -----
module ailp_dp #(
    parameter int RESULT_WIDTH = 32,
    parameter int EXP_WIDTH    = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            s_char_in,
    input  ailp_pkg::dp_cmd_t     cmd,
    output ailp_pkg::dp_stat_t    stat,
    output logic [30:0]           m_value,
    output ailp_pkg::status_t     m_status
);
    import ailp_pkg::*;

    localparam int AW = RESULT_WIDTH - 1;   // accumulator width, LIMIT = all ones
    localparam int SW = AW + 6;             // product plus digit
    localparam int EW = EXP_WIDTH;
    localparam int XW = EW + 5;             // exponent times ten plus digit

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 5'(c - CH_ZERO);
        end else if (c >= CH_UPA && c <= CH_UPF) begin
            d = 5'(c - CH_UPA) + 5'd10;
        end else if (c >= CH_LOWA && c <= CH_LOWF) begin
            d = 5'(c - CH_LOWA) + 5'd10;
        end else begin
            d = NO_DIGIT;
        end
        return d;
    endfunction

    phase_t        phase_reg, phase_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [4:0]    base_reg, base_next;
    logic [EW-1:0] exp_reg, exp_next;
    status_t       err_reg, err_next;
    logic          halt_reg, halt_next;
    logic [30:0]   value_reg, value_next;
    status_t       status_reg;

    logic [4:0]    digit;
    logic          dig10, in_base, is_delim, is_exp;
    logic [3:0]    addend;
    logic [SW-1:0] mac;
    logic          mac_ovf;
    logic [XW-1:0] emac;
    logic          emac_sat;
    logic          bad_end;
    logic [62:0]   acc_wide;
    logic [62:0]   limit_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load) begin
            phase_reg <= PH_FIRST;
            acc_reg   <= '0;
            base_reg  <= BASE_TEN;
            exp_reg   <= '0;
            err_reg   <= STAT_OK;
            halt_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            exp_reg   <= exp_next;
            err_reg   <= err_next;
            halt_reg  <= halt_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg  <= value_next;
            status_reg <= err_reg;
        end
    end

    always_comb begin
        digit    = digit_of(s_char_in);
        dig10    = digit < 5'd10;
        in_base  = digit < base_reg;
        is_delim = (s_char_in == CH_HASH) || (s_char_in == CH_COLON);
        is_exp   = (s_char_in == CH_UPE) || (s_char_in == CH_LOWE);

        // shared multiply-add: acc * base + digit (digit zero while scaling)
        addend   = cmd.scale ? 4'd0 : digit[3:0];
        mac      = SW'(acc_reg) * SW'(base_reg) + SW'(addend);
        mac_ovf  = |mac[SW-1:AW];

        emac     = XW'(exp_reg) * XW'(5'd10) + XW'(digit[3:0]);
        emac_sat = |emac[XW-1:EW];

        bad_end  = (phase_reg == PH_FIRST) || (phase_reg == PH_BFIRST) ||
                   (phase_reg == PH_ESTART) || (phase_reg == PH_EFIRST);

        acc_wide   = 63'(acc_reg);
        limit_wide = 63'({AW{1'b1}});
        if (err_reg == STAT_OK) begin
            value_next = acc_wide[30:0];
        end else if (err_reg == STAT_OVERFLOW) begin
            value_next = limit_wide[30:0];
        end else begin
            value_next = '0;
        end

        phase_next = phase_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        err_next   = err_reg;
        halt_next  = halt_reg;
        stat.scale_done = 1'b0;

        if (cmd.take && err_reg == STAT_OK && !halt_reg) begin
            unique case (phase_reg)
                PH_FIRST: begin
                    if (dig10) begin
                        acc_next   = AW'(digit[3:0]);
                        phase_next = PH_DEC;
                    end else begin
                        err_next = STAT_BAD_FIRST;
                    end
                end
                PH_DEC: begin
                    if (dig10) begin
                        if (mac_ovf) err_next = STAT_OVERFLOW;
                        else         acc_next = mac[AW-1:0];
                    end else if (s_char_in == CH_UNDER) begin
                        acc_next = acc_reg;
                    end else if (is_delim) begin
                        if (acc_reg < AW'(2) || acc_reg > AW'(16)) begin
                            err_next = STAT_BAD_BASE;
                        end else begin
                            base_next  = acc_reg[4:0];
                            acc_next   = '0;
                            phase_next = PH_BFIRST;
                        end
                    end else if (s_char_in == CH_DOT) begin
                        err_next = STAT_DEC_POINT;
                    end else if (is_exp) begin
                        phase_next = PH_ESTART;
                    end else begin
                        halt_next = 1'b1;
                    end
                end
                PH_BFIRST: begin
                    if (in_base) begin
                        acc_next   = AW'(digit[3:0]);
                        phase_next = PH_BASED;
                    end else begin
                        err_next = STAT_BAD_FIRST;
                    end
                end
                PH_BASED: begin
                    if (in_base) begin
                        if (mac_ovf) err_next = STAT_OVERFLOW;
                        else         acc_next = mac[AW-1:0];
                    end else if (s_char_in == CH_UNDER) begin
                        acc_next = acc_reg;
                    end else if (is_delim) begin
                        phase_next = PH_AFTERB;
                    end else if (s_char_in == CH_DOT) begin
                        err_next = STAT_DEC_POINT;
                    end else begin
                        halt_next = 1'b1;
                    end
                end
                PH_AFTERB: begin
                    if (is_exp) phase_next = PH_ESTART;
                    else        halt_next  = 1'b1;
                end
                PH_ESTART: begin
                    if (s_char_in == CH_MINUS) begin
                        err_next = STAT_NEG_EXP;
                    end else if (s_char_in == CH_PLUS) begin
                        phase_next = PH_EFIRST;
                    end else if (dig10) begin
                        exp_next   = EW'(digit[3:0]);
                        phase_next = PH_EXP;
                    end else begin
                        err_next = STAT_BAD_FIRST;
                    end
                end
                PH_EFIRST: begin
                    if (dig10) begin
                        exp_next   = EW'(digit[3:0]);
                        phase_next = PH_EXP;
                    end else begin
                        err_next = STAT_BAD_FIRST;
                    end
                end
                PH_EXP: begin
                    if (dig10) begin
                        exp_next = emac_sat ? {EW{1'b1}} : emac[EW-1:0];
                    end else if (s_char_in != CH_UNDER) begin
                        halt_next = 1'b1;
                    end
                end
                default: begin
                    halt_next = 1'b1;
                end
            endcase
        end

        // end of literal: missing-digit check, then one base multiply per cycle
        if (cmd.scale) begin
            priority if (err_reg != STAT_OK) begin
                stat.scale_done = 1'b1;
            end else if (bad_end) begin
                err_next        = STAT_BAD_FIRST;
                stat.scale_done = 1'b1;
            end else if (exp_reg == '0 || acc_reg == '0) begin
                stat.scale_done = 1'b1;
            end else if (mac_ovf) begin
                err_next        = STAT_OVERFLOW;
                stat.scale_done = 1'b1;
            end else begin
                acc_next = mac[AW-1:0];
                exp_next = exp_reg - EW'(1);
            end
        end
    end

    assign m_value  = value_reg;
    assign m_status = status_reg;

endmodule

// ----- design/ada_integer_literal_parser.sv -----
// Sequence: a character that is not last is taken on its transfer. After the last
//   character, a scaling pass with k multiplies by the base (k <= exponent and
//   at most about RESULT_WIDTH before overflow), a load once the output is free, then m_valid.
// Throughput: 1 character per cycle while accepting; after the last character, intake
//   stops until its result is loaded, as the shared accumulator multiply-add does the scaling.
// Reset: synchronous, active-low aresetn clears parse state and controller.
module ada_integer_literal_parser #(
    parameter int RESULT_WIDTH = 32,
    parameter int EXP_WIDTH    = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    // character input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_char_in,
    input  logic              s_is_last,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [30:0]       m_value,
    output ailp_pkg::status_t m_status
);
    import ailp_pkg::*;

    // Command/status bundle between the sequencer and the datapath:
    //   take  - a character transfer; the character is decoded and folded into
    //           the accumulator (digit), base, or exponent in the same cycle.
    //   scale - one step of the end-of-literal pass: checks for a missing
    //           digit, then multiplies the accumulator by the base once per
    //           cycle while the exponent count and the accumulator are nonzero.
    //   load  - the result register is free; capture value/status and restart
    //           the parse for the next literal.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    ailp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_is_last (s_is_last),
        .s_ready   (s_ready),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Datapath: character decode, accumulator with one shared multiply-add,
    // saturating exponent, sticky error code and the result register.
    ailp_dp #(
        .RESULT_WIDTH (RESULT_WIDTH),
        .EXP_WIDTH    (EXP_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_char_in (s_char_in),
        .cmd       (cmd),
        .stat      (stat),
        .m_value   (m_value),
        .m_status  (m_status)
    );

`ifndef SYNTHESIS
    // The last character stops intake until its result has been loaded.
    a_stop_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_is_last) |=> !s_ready)
        else $error("input taken while literal end is being processed");

    // A result is only loaded into a free output register.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_valid || m_ready))
        else $error("result register overwritten before transfer");

    // Parse errors other than overflow report a zero value.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_OK && m_status != STAT_OVERFLOW)
        |-> (m_value == '0))
        else $error("nonzero value reported with a parse error");
`endif

endmodule

// ----- bench/tb_ada_integer_literal_parser.sv -----
module tb_ada_integer_literal_parser;

    import ailp_pkg::*;

    // Parser build under test: defaults of the block
    localparam int RES_W  = 32;
    localparam int EXPO_W = 16;

    localparam logic [63:0] VAL_LIMIT = (64'd1 << (RES_W - 1)) - 64'd1;
    localparam logic [63:0] EXPO_MAX  = (64'd1 << EXPO_W) - 64'd1;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 5;
    localparam int STIM_ITEMS  = 900;
    localparam int IDLE_PCT    = 17;
    localparam int DRAIN_LEN   = 40;      // scaling run plus load/output
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;
    localparam int DIR_ROWS    = 10;

    // One converted literal as seen on the result channel
    typedef struct packed {
        logic [30:0] value;
        status_t     status;
    } literal_result_t;

    // Directed row expectation; known = 0 means "ask the predictor"
    typedef struct packed {
        logic            known;
        literal_result_t res;
    } dir_expect_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [7:0]        s_char_in = '0;
    logic              s_is_last = 1'b0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [30:0]       m_value;
    status_t           m_status;

    // Random gaps on both channels; cleared for a stretch of steady traffic
    logic gaps_on = 1'b1;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int items_sent     = 0;

    literal_result_t pending_results [$];
    logic [7:0]      lit_chars [$];

    // Shadow parse state of the converter
    phase_t      lit_phase;
    logic [63:0] lit_acc;
    logic [4:0]  lit_base;
    logic [63:0] lit_exp;
    status_t     lit_err;
    logic        lit_halt;

    // Directed literals: extremes, each status code and the odd corners
    string dir_text [DIR_ROWS] = '{
        "0",     // smallest literal
        "x",     // non-digit first character
        "1.",    // decimal point
        "1#",    // base below two
        "2E-",   // minus sign on exponent
        "9E9",   // scaling overflows, saturated value
        "15#e",  // e is digit 14, valid in base 15; closing delimiter never comes
        "1_2x",  // underscore skipped, trailing text stops the parse
        "2#",    // literal ends where a based digit is due
        "1E"     // literal ends where an exponent digit is due
    };

    dir_expect_t dir_expect [DIR_ROWS] = '{
        '{1'b1, '{31'd0, STAT_OK}},
        '{1'b1, '{31'd0, STAT_BAD_FIRST}},
        '{1'b1, '{31'd0, STAT_DEC_POINT}},
        '{1'b1, '{31'd0, STAT_BAD_BASE}},
        '{1'b1, '{31'd0, STAT_NEG_EXP}},
        '{1'b1, '{VAL_LIMIT[30:0], STAT_OVERFLOW}},
        '{1'b0, '{31'd0, STAT_OK}},
        '{1'b0, '{31'd0, STAT_OK}},
        '{1'b1, '{31'd0, STAT_BAD_FIRST}},
        '{1'b1, '{31'd0, STAT_BAD_FIRST}}
    };

    ada_integer_literal_parser #(
        .RESULT_WIDTH (RES_W),
        .EXP_WIDTH    (EXPO_W)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_char_in (s_char_in),
        .s_is_last (s_is_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value),
        .m_status  (m_status)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Converter prediction
    // ------------------------------------------------------------------

    // Hex digit value of a character, NO_DIGIT for anything else
    function automatic logic [4:0] digit_value(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
        if (c >= CH_UPA && c <= CH_UPF) return 5'(c - CH_UPA) + BASE_TEN;
        if (c >= CH_LOWA && c <= CH_LOWF) return 5'(c - CH_LOWA) + BASE_TEN;
        return NO_DIGIT;
    endfunction

    function automatic void clear_literal();
        lit_phase = PH_FIRST;
        lit_acc   = '0;
        lit_base  = BASE_TEN;
        lit_exp   = '0;
        lit_err   = STAT_OK;
        lit_halt  = 1'b0;
    endfunction

    // value = value * base + d, flagging overflow past the saturation limit
    function automatic void grow_value(logic [4:0] d);
        if (lit_acc > (VAL_LIMIT - 64'(d)) / 64'(lit_base)) begin
            lit_err = STAT_OVERFLOW;
        end else begin
            lit_acc = lit_acc * 64'(lit_base) + 64'(d);
        end
    endfunction

    function automatic void scan_char(logic [7:0] c);
        logic [4:0] d;
        logic       delim;
        logic       exp_mark;
        d        = digit_value(c);
        delim    = (c == CH_HASH) || (c == CH_COLON);
        exp_mark = (c == CH_UPE) || (c == CH_LOWE);
        unique case (lit_phase)
            PH_FIRST: begin
                if (d < BASE_TEN) begin
                    lit_acc   = 64'(d);
                    lit_phase = PH_DEC;
                end else begin
                    lit_err = STAT_BAD_FIRST;
                end
            end
            PH_DEC: begin
                if (d < BASE_TEN) begin
                    grow_value(d);
                end else if (c == CH_UNDER) begin
                    // separator, skipped
                end else if (delim) begin
                    if (lit_acc < 64'd2 || lit_acc > 64'd16) begin
                        lit_err = STAT_BAD_BASE;
                    end else begin
                        lit_base  = lit_acc[4:0];
                        lit_acc   = '0;
                        lit_phase = PH_BFIRST;
                    end
                end else if (c == CH_DOT) begin
                    lit_err = STAT_DEC_POINT;
                end else if (exp_mark) begin
                    lit_phase = PH_ESTART;
                end else begin
                    lit_halt = 1'b1;
                end
            end
            PH_BFIRST: begin
                if (d < lit_base) begin
                    lit_acc   = 64'(d);
                    lit_phase = PH_BASED;
                end else begin
                    lit_err = STAT_BAD_FIRST;
                end
            end
            PH_BASED: begin
                if (d < lit_base) begin
                    grow_value(d);
                end else if (c == CH_UNDER) begin
                    // separator, skipped
                end else if (delim) begin
                    lit_phase = PH_AFTERB;
                end else if (c == CH_DOT) begin
                    lit_err = STAT_DEC_POINT;
                end else begin
                    lit_halt = 1'b1;
                end
            end
            PH_AFTERB: begin
                if (exp_mark) lit_phase = PH_ESTART;
                else lit_halt = 1'b1;
            end
            PH_ESTART: begin
                if (c == CH_MINUS) begin
                    lit_err = STAT_NEG_EXP;
                end else if (c == CH_PLUS) begin
                    lit_phase = PH_EFIRST;
                end else if (d < BASE_TEN) begin
                    lit_exp   = 64'(d);
                    lit_phase = PH_EXP;
                end else begin
                    lit_err = STAT_BAD_FIRST;
                end
            end
            PH_EFIRST: begin
                if (d < BASE_TEN) begin
                    lit_exp   = 64'(d);
                    lit_phase = PH_EXP;
                end else begin
                    lit_err = STAT_BAD_FIRST;
                end
            end
            default: begin
                if (d < BASE_TEN) begin
                    lit_exp = lit_exp * 64'(BASE_TEN) + 64'(d);
                    if (lit_exp > EXPO_MAX) lit_exp = EXPO_MAX;
                end else if (c != CH_UNDER) begin
                    lit_halt = 1'b1;
                end
            end
        endcase
    endfunction

    // End of literal: a digit still due is an error, else scale by base^exp
    function automatic void scale_value();
        logic [63:0] n;
        if (lit_phase == PH_FIRST || lit_phase == PH_BFIRST ||
            lit_phase == PH_ESTART || lit_phase == PH_EFIRST) begin
            lit_err = STAT_BAD_FIRST;
            return;
        end
        n = lit_exp;
        while (n != 0 && lit_acc != 0 && lit_err == STAT_OK) begin
            if (lit_acc > VAL_LIMIT / 64'(lit_base)) lit_err = STAT_OVERFLOW;
            else lit_acc = lit_acc * 64'(lit_base);
            n = n - 64'd1;
        end
    endfunction

    // One accepted character; got is set when it closes a literal
    function automatic void convert_char(input logic [7:0] c, input logic is_end,
                                         output logic got, output literal_result_t res);
        if (lit_err == STAT_OK && !lit_halt) scan_char(c);
        got = is_end;
        res = '0;
        if (is_end) begin
            if (lit_err == STAT_OK) scale_value();
            res.status = lit_err;
            if (lit_err == STAT_OK) res.value = lit_acc[30:0];
            else if (lit_err == STAT_OVERFLOW) res.value = VAL_LIMIT[30:0];
            clear_literal();
        end
    endfunction

    // ------------------------------------------------------------------
    // Character channel
    // ------------------------------------------------------------------

    // Drive one character and hold it until the transfer. Valid stays high
    // after a transfer so back-to-back characters need no gap.
    task automatic send_char(input logic [7:0] c, input logic is_end,
                             input logic typed_on, input literal_result_t typed);
        logic            got;
        literal_result_t res;
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= c;
        s_is_last <= is_end;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        convert_char(c, is_end, got, res);
        if (got) pending_results.insert(pending_results.size(), typed_on ? typed : res);
    endtask

    task automatic send_literal();
        for (int i = 0; i < lit_chars.size(); i++) begin
            send_char(lit_chars[i], i == lit_chars.size() - 1, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Random literal builder
    // ------------------------------------------------------------------

    // Append one character to the literal under construction
    function automatic void put_char(logic [7:0] c);
        lit_chars.insert(lit_chars.size(), c);
    endfunction

    // n digits below base, letters in either case, underscores now and then
    task automatic add_digits(input int base, input int n);
        int d;
        for (int i = 0; i < n; i++) begin
            d = $urandom_range(0, base - 1);
            if (d < 10) put_char(CH_ZERO + 8'(d));
            else if ($urandom_range(0, 1) == 1) put_char(CH_UPA + 8'(d - 10));
            else put_char(CH_LOWA + 8'(d - 10));
            if ($urandom_range(0, 99) < 12) put_char(CH_UNDER);
        end
    endtask

    task automatic add_text(input string txt);
        for (int i = 0; i < txt.len(); i++) put_char(txt[i]);
    endtask

    // Mostly well-formed literals with random content; some noise, some
    // damaged or cut short, some with trailing text.
    task automatic build_literal();
        int pick;
        int base_v;
        int sign_pick;
        int cut;
        logic [7:0] junk [7];
        lit_chars.delete();
        junk = '{CH_DOT, CH_UNDER, CH_HASH, CH_COLON, CH_MINUS, CH_PLUS, CH_UPE};
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6)) put_char(8'($urandom_range(0, 255)));
            return;
        end
        if (pick < 50) begin
            // based literal; an occasional base out of range
            if ($urandom_range(0, 19) == 0) base_v = $urandom_range(0, 40);
            else base_v = $urandom_range(2, 16);
            if ($urandom_range(0, 9) == 0) put_char(CH_ZERO);
            if (base_v >= 10) put_char(CH_ZERO + 8'(base_v / 10));
            put_char(CH_ZERO + 8'(base_v % 10));
            put_char($urandom_range(0, 1) ? CH_HASH : CH_COLON);
            if (base_v < 2) base_v = 2;
            if (base_v > 16) base_v = 16;
            add_digits(base_v, $urandom_range(1, 9));
            if ($urandom_range(0, 9) != 0) begin
                put_char($urandom_range(0, 1) ? CH_HASH : CH_COLON);
            end
        end else if (pick < 53) begin
            // right at and just past the saturation limit
            add_text($urandom_range(0, 1) ? "2147483647" : "2147483648");
        end else if ($urandom_range(0, 9) == 0) begin
            add_digits(10, $urandom_range(8, 12));
        end else begin
            add_digits(10, $urandom_range(1, 5));
        end
        if ($urandom_range(0, 99) < 35) begin
            put_char($urandom_range(0, 1) ? CH_UPE : CH_LOWE);
            sign_pick = $urandom_range(0, 99);
            if (sign_pick < 10) put_char(CH_MINUS);
            else if (sign_pick < 30) put_char(CH_PLUS);
            // long exponents can hit the magnitude clamp
            if ($urandom_range(0, 19) == 0) add_digits(10, $urandom_range(5, 7));
            else add_digits(10, $urandom_range(1, 2));
        end
        if ($urandom_range(0, 99) < 15) begin
            cut = $urandom_range(0, lit_chars.size() - 1);
            if ($urandom_range(0, 3) == 0) lit_chars[cut] = 8'($urandom_range(0, 255));
            else lit_chars[cut] = junk[$urandom_range(0, 6)];
        end
        if ($urandom_range(0, 99) < 8) begin
            cut = $urandom_range(1, lit_chars.size());
            while (lit_chars.size() > cut) void'(lit_chars.pop_back());
        end
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 3)) put_char(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Result channel: random back-pressure and checking
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (gaps_on) m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        else m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        literal_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < REPORT_MAX) begin
                    $display("unexpected result: value %0d status %0d", m_value, m_status);
                end
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_value !== want.value || m_status !== want.status) begin
                    if (mismatch_count < REPORT_MAX) begin
                        $display("mismatch: value %0d status %0d, expected value %0d status %0d",
                                 m_value, m_status, want.value, want.status);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Run-away guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_ada_integer_literal_parser: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin
        logic paused;
        paused = 1'b0;
        clear_literal();

        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, one literal per row
        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int i = 0; i < dir_text[r].len(); i++) begin
                send_char(dir_text[r][i], i == dir_text[r].len() - 1,
                          dir_expect[r].known, dir_expect[r].res);
            end
        end

        // Random literals; a quiet stretch with no gaps on either side,
        // and one hold-off until every result is back
        while (items_sent < STIM_ITEMS) begin
            gaps_on <= !(items_sent >= 350 && items_sent < 550);
            if (!paused && items_sent >= 650) begin
                paused  = 1'b1;
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_results.size() != 0) @(posedge aclk);
            end
            build_literal();
            send_literal();
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_LEN) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tb_ada_integer_literal_parser: clean");
        end else begin
            $display("tb_ada_integer_literal_parser: errors");
        end
        $finish;
    end

endmodule
